// ----- design/zts_pkg.sv -----
`default_nettype none

package zts_pkg;

    localparam logic [31:0] KEY_ZERO_INIT = 32'h1234_5678;
    localparam logic [31:0] KEY_ONE_INIT  = 32'h2345_6789;
    localparam logic [31:0] KEY_TWO_INIT  = 32'h3456_7890;
    localparam logic [31:0] KEY_ONE_MUL   = 32'd134775813;
    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ABSORB  = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic k0;
        logic k1;
        logic k2;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    // One reflected CRC-32 byte step, no inversion.
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ----- design/zip_traditional_stream_cipher.sv -----
`default_nettype none

// Channel   Handshake            Payload
// input     i_valid / o_ready    i_cmd[1:0], i_data_byte[7:0]
// output    o_valid / i_ready    o_out_byte[7:0]
//
// An encrypt, decrypt or absorb item runs from acceptance to the output
// register through the states ST_K0, ST_K1 and ST_K2: the accept state forms
// the keystream byte, then those states update key zero, key one and key two
// in turn. An init item reloads the starting keys on acceptance and goes
// straight to ST_OUT. Reset loads the fixed starting keys and empties the
// output register. A stalled output holds the finished item and the
// controller waits before accepting another one.
module zip_traditional_stream_cipher import zts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte
);

    t_dp_cmd w_dp_cmd;
    t_dp_sts w_dp_sts;

    // The controller sequences the key update steps of each item.
    zts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd    (i_cmd),
        .o_ready  (o_ready),
        .o_dp_cmd (w_dp_cmd),
        .i_dp_sts (w_dp_sts)
    );

    // The datapath holds the three keys, the keystream logic and the output
    // register.
    zts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_dp_cmd    (w_dp_cmd),
        .o_dp_sts    (w_dp_sts),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte)
    );

endmodule

`default_nettype wire

// ----- design/zts_ctrl.sv -----
`default_nettype none

module zts_ctrl import zts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_cmd,
    output logic            o_ready,
    output t_dp_cmd         o_dp_cmd,
    input  wire t_dp_sts    i_dp_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        o_dp_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state = (t_op'(i_cmd) == OP_INIT) ? ST_OUT : ST_K0;
                end
            end
            ST_K0: begin
                o_dp_cmd.k0 = 1'b1;
                n_state = ST_K1;
            end
            ST_K1: begin
                o_dp_cmd.k1 = 1'b1;
                n_state = ST_K2;
            end
            ST_K2: begin
                o_dp_cmd.k2 = 1'b1;
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.push = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_dp_sts.out_free) begin
                    o_dp_cmd.push = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/zts_dp.sv -----
`default_nettype none

module zts_dp import zts_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_data_byte,
    input  wire t_dp_cmd    i_dp_cmd,
    output t_dp_sts         o_dp_sts,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte
);

    logic [31:0] r_key_zero;
    logic [31:0] r_key_one;
    logic [31:0] r_key_two;
    logic [31:0] r_sum;
    logic [7:0]  r_plain;
    logic [7:0]  r_res;
    logic        r_valid;
    logic [7:0]  r_out_byte;

    logic [15:0] w_t;
    logic [15:0] w_prod;
    logic [7:0]  w_ks;
    logic [7:0]  w_xor;
    logic [31:0] n_key_zero;
    t_op         w_op;

    // Only the low 16 bits of the keystream product matter.
    assign w_op       = t_op'(i_cmd);
    assign w_t        = r_key_two[15:0] | 16'd2;
    assign w_prod     = w_t * (w_t ^ 16'd1);
    assign w_ks       = w_prod[15:8];
    assign w_xor      = i_data_byte ^ w_ks;
    assign n_key_zero = crc_byte(r_key_zero, r_plain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_zero <= KEY_ZERO_INIT;
            r_key_one  <= KEY_ONE_INIT;
            r_key_two  <= KEY_TWO_INIT;
        end else begin
            if (i_dp_cmd.load && w_op == OP_INIT) begin
                r_key_zero <= KEY_ZERO_INIT;
                r_key_one  <= KEY_ONE_INIT;
                r_key_two  <= KEY_TWO_INIT;
            end
            if (i_dp_cmd.k0) begin
                r_key_zero <= n_key_zero;
            end
            if (i_dp_cmd.k1) begin
                r_key_one <= r_sum * KEY_ONE_MUL + 32'd1;
            end
            if (i_dp_cmd.k2) begin
                r_key_two <= crc_byte(r_key_two, r_key_one[31:24]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            unique case (w_op)
                OP_INIT, OP_ABSORB: begin
                    r_res   <= 8'd0;
                    r_plain <= i_data_byte;
                end
                OP_ENCRYPT: begin
                    r_res   <= w_xor;
                    r_plain <= i_data_byte;
                end
                OP_DECRYPT: begin
                    r_res   <= w_xor;
                    r_plain <= w_xor;
                end
                default: begin
                    r_res   <= 8'd0;
                    r_plain <= i_data_byte;
                end
            endcase
        end
        if (i_dp_cmd.k0) begin
            r_sum <= r_key_one + {24'd0, n_key_zero[7:0]};
        end
        if (i_dp_cmd.push) begin
            r_out_byte <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_dp_cmd.push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_dp_sts.out_free = !r_valid || i_ready;
    assign o_valid           = r_valid;
    assign o_out_byte        = r_out_byte;

endmodule

`default_nettype wire

// ----- design/zts_checker.sv -----
`default_nettype none

module zts_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_out_byte
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after an accepted item");

    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared without a busy cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_out_byte)))
        else $error("stalled result changed");

endmodule

bind zip_traditional_stream_cipher zts_checker u_zts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_out_byte (o_out_byte)
);

`default_nettype wire

// ----- dv/tb_zip_traditional_stream_cipher.sv -----
`default_nettype none

module tb_zip_traditional_stream_cipher;
    import zts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Starting keys and cipher constants, kept apart from the package so that
    // a wrong value there cannot hide behind the prediction.
    localparam logic [31:0] START_CRC_A    = 32'h1234_5678;
    localparam logic [31:0] START_LCG      = 32'h2345_6789;
    localparam logic [31:0] START_CRC_B    = 32'h3456_7890;
    localparam logic [31:0] LCG_MUL        = 32'd134775813;
    localparam logic [31:0] POLY_REFLECTED = 32'hEDB8_8320;

    // Cycles allowed after the last result before the run ends.
    localparam int SETTLE_CYCLES = 8;

    // Items sent with random idling, then a closing stretch with none.
    localparam int IDLE_ITEMS  = 1100;
    localparam int QUIET_ITEMS = 150;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_op        in_cmd;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;

    // The three cipher keys as the predictor tracks them.
    typedef struct packed {
        logic [31:0] crc_a;
        logic [31:0] lcg;
        logic [31:0] crc_b;
    } cipher_keys_t;

    // One result byte still owed by the block, with the command that caused it.
    typedef struct {
        t_op        op;
        logic [7:0] val;
    } owed_byte_t;

    cipher_keys_t keys;
    owed_byte_t   owed_bytes[$];
    owed_byte_t   head;

    bit idle_on;
    int stall_left;
    int errors;
    int items_sent;
    int results_checked;
    int sessions;
    int op_count[4];

    zip_traditional_stream_cipher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (in_ready),
        .i_cmd       (in_cmd),
        .i_data_byte (in_byte),
        .o_valid     (out_valid),
        .i_ready     (out_ready),
        .o_out_byte  (out_byte)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One byte of a reflected CRC-32 register, no inversion on either side.
    function automatic logic [31:0] crc_shift8(input logic [31:0] reg_in, input logic [7:0] b);
        logic [31:0] r;
        r = reg_in ^ {24'h0, b};
        repeat (8) begin
            r = r[0] ? ({1'b0, r[31:1]} ^ POLY_REFLECTED) : {1'b0, r[31:1]};
        end
        return r;
    endfunction

    // The keystream byte depends only on the low 16 bits of the product, so a
    // 32-bit multiply is enough.
    function automatic logic [7:0] keystream_byte(input logic [31:0] k);
        logic [31:0] t;
        logic [31:0] prod;
        t = k | 32'h2;
        prod = t * (t ^ 32'h1);
        return prod[15:8];
    endfunction

    // Folds one plaintext or password byte into the keys. Each key feeds the
    // next one, so the order of the three updates matters.
    function automatic void mix_keys(input logic [7:0] p);
        keys.crc_a = crc_shift8(keys.crc_a, p);
        keys.lcg   = (keys.lcg + {24'h0, keys.crc_a[7:0]}) * LCG_MUL + 32'd1;
        keys.crc_b = crc_shift8(keys.crc_b, keys.lcg[31:24]);
    endfunction

    // Returns the byte the block must produce for one item and advances the
    // keys. Decrypt updates the keys with the recovered plaintext, never with
    // the ciphertext that came in.
    function automatic logic [7:0] cipher_step(input t_op op, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        case (op)
            OP_INIT: begin
                keys = '{crc_a: START_CRC_A, lcg: START_LCG, crc_b: START_CRC_B};
            end
            OP_ABSORB: begin
                mix_keys(b);
            end
            OP_ENCRYPT: begin
                r = b ^ keystream_byte(keys.crc_b);
                mix_keys(b);
            end
            default: begin
                r = b ^ keystream_byte(keys.crc_b);
                mix_keys(r);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one item. It is entered at a falling edge and returns at the
    // falling edge after acceptance with valid still high, so that back-to-back
    // items keep valid up without a drop. When idling is on, a burst of idle
    // cycles may come first. The predicted result is handed back for tests
    // that reuse it.
    task automatic send_item(input t_op op, input logic [7:0] b, output logic [7:0] res);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= op;
        in_byte  <= b;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        res = cipher_step(op, b);
        owed_bytes.push_back('{op: op, val: res});
        items_sent++;
        op_count[op]++;
        @(negedge clk);
    endtask

    // Lowers valid and waits until every owed byte has come back, then lets
    // the block settle. Tests call this between themselves.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (owed_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // The result side stalls in random bursts while idling is
    // on. It changes only at falling edges, one assignment per edge.
    initial begin
        out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (!idle_on) begin
                out_ready <= 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Every accepted result is matched against the oldest owed byte. The
    // values seen here are the ones from just before the edge.
    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            if (owed_bytes.size() == 0) begin
                $error("out_byte: result %02h arrived with no item pending", out_byte);
                errors++;
            end else begin
                head = owed_bytes.pop_front();
                if (out_byte !== head.val) begin
                    $error("out_byte (%s): expected %02h, actual %02h",
                           head.op.name(), head.val, out_byte);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Right after reset the keys must already hold their starting values,
    // with no init item needed.
    task automatic test_reset_keys();
        logic [7:0] r;
        send_item(OP_ENCRYPT, 8'h00, r);
        send_item(OP_DECRYPT, 8'hFF, r);
        drain_results();
    endtask

    // All four commands with the data byte at both ends of its range. The
    // init carries a nonzero byte that it must ignore.
    task automatic test_field_extremes();
        logic [7:0] r;
        send_item(OP_INIT, 8'hFF, r);
        send_item(OP_ABSORB, 8'h00, r);
        send_item(OP_ABSORB, 8'hFF, r);
        send_item(OP_ENCRYPT, 8'h00, r);
        send_item(OP_ENCRYPT, 8'hFF, r);
        send_item(OP_DECRYPT, 8'h00, r);
        send_item(OP_DECRYPT, 8'hFF, r);
        drain_results();
    endtask

    // Encrypts under a short password, then re-keys with the same password
    // and decrypts the ciphertext, which must give back the plaintext.
    task automatic test_password_roundtrip();
        logic [7:0] plain[3];
        logic [7:0] cipher[3];
        logic [7:0] r;
        plain = '{8'h5A, 8'h00, 8'hFF};
        send_item(OP_INIT, 8'h00, r);
        send_item(OP_ABSORB, 8'h6B, r);
        send_item(OP_ABSORB, 8'h39, r);
        foreach (plain[i]) send_item(OP_ENCRYPT, plain[i], cipher[i]);
        send_item(OP_INIT, 8'hA5, r);
        send_item(OP_ABSORB, 8'h6B, r);
        send_item(OP_ABSORB, 8'h39, r);
        foreach (cipher[i]) send_item(OP_DECRYPT, cipher[i], r);
        drain_results();
        sessions += 2;
    endtask

    // Absorb with no init before it must carry on from whatever keys are held.
    task automatic test_absorb_continue();
        logic [7:0] r;
        send_item(OP_ABSORB, 8'h31, r);
        send_item(OP_ABSORB, 8'h80, r);
        send_item(OP_ENCRYPT, 8'h42, r);
        drain_results();
    endtask

    // Mostly well-formed sessions: init, a password of up to a dozen bytes and
    // a body of 12 to 52 bytes, all in one direction. Half the encrypt
    // sessions are replayed as decrypt under the same password. About one
    // round in five is noise instead: commands and bytes picked at random.
    task automatic test_random_sessions(input int n_items, input bit with_idle);
        int         stop_at;
        int         pw_len;
        int         body_len;
        int         noise_len;
        bit         decrypt_dir;
        logic [7:0] pw[$];
        logic [7:0] cipher[$];
        logic [7:0] r;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            // Stretches with and without idling, chosen at random.
            idle_on = with_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
                pw.delete();
                cipher.delete();
                pw_len = $urandom_range(0, 12);
                body_len = 12 + $urandom_range(0, 40);
                decrypt_dir = $urandom_range(0, 1);
                send_item(OP_INIT, 8'($urandom), r);
                repeat (pw_len) begin
                    pw.push_back(8'($urandom));
                    send_item(OP_ABSORB, pw[$], r);
                end
                repeat (body_len) begin
                    send_item(decrypt_dir ? OP_DECRYPT : OP_ENCRYPT, 8'($urandom), r);
                    cipher.push_back(r);
                end
                sessions++;
                if (!decrypt_dir && $urandom_range(0, 1) == 1) begin
                    send_item(OP_INIT, 8'($urandom), r);
                    foreach (pw[i]) send_item(OP_ABSORB, pw[i], r);
                    foreach (cipher[i]) send_item(OP_DECRYPT, cipher[i], r);
                    sessions++;
                end
            end else begin
                noise_len = $urandom_range(1, 8);
                repeat (noise_len) send_item(t_op'($urandom_range(0, 3)), 8'($urandom), r);
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_cmd   = OP_INIT;
        in_byte  = 8'h00;
        idle_on  = 1'b0;
        errors = 0;
        items_sent = 0;
        results_checked = 0;
        sessions = 0;
        op_count = '{default: 0};
        // Reset leaves the block holding its starting keys.
        keys = '{crc_a: START_CRC_A, lcg: START_LCG, crc_b: START_CRC_B};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_on = 1'b1;
        test_reset_keys();
        test_field_extremes();
        test_password_roundtrip();
        test_absorb_continue();
        test_random_sessions(IDLE_ITEMS, 1'b1);

        // The closing stretch runs with no idling or stalls on either side.
        idle_on = 1'b0;
        test_random_sessions(QUIET_ITEMS, 1'b0);

        if (owed_bytes.size() != 0) begin
            $error("out_byte: %0d results never arrived", owed_bytes.size());
            errors++;
        end

        $display("Sent %0d items (%0d init, %0d absorb, %0d encrypt, %0d decrypt).",
                 items_sent, op_count[OP_INIT], op_count[OP_ABSORB],
                 op_count[OP_ENCRYPT], op_count[OP_DECRYPT]);
        $display("Checked %0d result bytes over %0d password sessions.",
                 results_checked, sessions);
        if (errors == 0) begin
            $display("zip_traditional_stream_cipher regression: pass");
        end else begin
            $display("zip_traditional_stream_cipher regression: fail");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this time, even with every
    // item waiting out the longest gap and the longest stall.
    initial begin
        #2_000_000;
        $display("zip_traditional_stream_cipher regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ----- zip_traditional_stream_cipher.f -----
design/zts_pkg.sv
design/zts_ctrl.sv
design/zts_dp.sv
design/zip_traditional_stream_cipher.sv
design/zts_checker.sv
dv/tb_zip_traditional_stream_cipher.sv
